// ----- rtl/core/bps_pkg.sv -----
// Shared types, constants and helper functions for the ball point sampler.
package bps_pkg;

  // Defaults for the top-level parameters
  localparam int ROTATION_STAGES_DEF = 16;
  localparam int FRACTION_BITS_DEF   = 16;

  // Square root digit steps: one result bit per cell, 31 result bits
  localparam int SQRT_STEPS = 31;

  // Fixed-point constants in Q2.30
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [34:0] Q30_ONE         = 35'sd1073741824;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_CENTER_X = 3'd1;
  localparam logic [2:0] REG_CENTER_Y = 3'd2;
  localparam logic [2:0] REG_CENTER_Z = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;

  // Data handed from cell to cell
  typedef struct packed {
    logic signed [33:0] x;     // rotation vector, Q2.30
    logic signed [33:0] y;
    logic signed [32:0] z;     // residual phase, one turn = 2^32
    logic [1:0]         quad;  // quadrant of the angle
    logic [31:0]        rem;   // square root partial remainder
    logic [30:0]        root;  // square root partial result
    logic [61:0]        rad;   // square root radicand, Q2.60
    logic signed [31:0] h;     // height, Q2.30 (sphere mode)
  } cell_t;

  // Configuration register bank
  typedef struct packed {
    logic               mode;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } cfg_t;

  // Arctangent of 2^-i, one turn = 2^32
  function automatic logic [29:0] atan_phase(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Saturate a fraction to 1.0 and widen it to Q1.30
  function automatic logic [30:0] fraction_q30(input logic [16:0] raw, input int fb);
    logic [30:0] f;
    logic [30:0] one;
    f   = {14'd0, raw};
    one = 31'd1 << fb;
    if (f > one) f = one;
    return f << (30 - fb);
  endfunction

  // Clamp to [-1, 1] in Q2.30
  function automatic logic signed [31:0] clamp_unit(input logic signed [34:0] v);
    logic signed [34:0] r;
    r = v;
    if (v > Q30_ONE) r = Q30_ONE;
    if (v < -Q30_ONE) r = -Q30_ONE;
    return r[31:0];
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

endpackage

// ----- rtl/core/bps_cell.sv -----
// One cell of the chain: a rotation step and a square root digit step.
module bps_cell import bps_pkg::*; #(
  parameter int IDX = 0,
  parameter int ROT = ROTATION_STAGES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  vin,
  input  cell_t din,
  output logic  vout,
  output cell_t dout
);

  cell_t nxt;

  // Rotation step (cells past the stage count pass the vector on)
  cell_t rot;
  generate
    if (IDX < ROT) begin : g_rot
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [32:0] ang;
      assign dx  = din.y >>> IDX;
      assign dy  = din.x >>> IDX;
      assign ang = $signed({3'b000, atan_phase(5'(IDX))});
      always_comb begin
        rot = din;
        if (din.z >= 0) begin
          rot.x = din.x - dx;
          rot.y = din.y + dy;
          rot.z = din.z - ang;
        end else begin
          rot.x = din.x + dx;
          rot.y = din.y - dy;
          rot.z = din.z + ang;
        end
      end
    end else begin : g_norot
      assign rot = din;
    end
  endgenerate

  // Square root digit step: take one radicand bit pair, emit one root bit
  generate
    if (IDX < SQRT_STEPS) begin : g_sqrt
      logic [33:0] shifted;
      logic [33:0] trial;
      assign shifted = {din.rem, din.rad[61-2*IDX -: 2]};
      assign trial   = {1'b0, din.root, 2'b01};
      always_comb begin
        nxt = rot;
        if (shifted >= trial) begin
          nxt.rem  = 32'(shifted - trial);
          nxt.root = {din.root[29:0], 1'b1};
        end else begin
          nxt.rem  = shifted[31:0];
          nxt.root = {din.root[29:0], 1'b0};
        end
      end
    end else begin : g_nosqrt
      assign nxt = rot;
    end
  endgenerate

  // Advance the cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/core/bps_post.sv -----
// Output stages: quadrant fold, scaling by radius, offset and saturation.
module bps_post import bps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  cell_t              din,
  input  cfg_t               cfg,
  output logic               out_valid,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z
);

  // Stage 1: fold quadrant, clamp, radius products
  logic signed [34:0] xe, ye;
  logic signed [34:0] c_raw, s_raw;
  logic               v1;
  logic signed [31:0] c1, s1;
  logic [61:0]        pm1;
  logic signed [63:0] pz1;

  assign xe = 35'(din.x);
  assign ye = 35'(din.y);

  always_comb begin
    case (din.quad)
      2'd0:    begin c_raw = xe;  s_raw = ye;  end
      2'd1:    begin c_raw = -ye; s_raw = xe;  end
      2'd2:    begin c_raw = -xe; s_raw = -ye; end
      default: begin c_raw = ye;  s_raw = -xe; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= clamp_unit(c_raw);
      s1  <= clamp_unit(s_raw);
      pm1 <= 62'(cfg.radius) * 62'(din.root);
      pz1 <= $signed({33'd0, cfg.radius}) * 64'(din.h);
    end
  end

  // Stage 2: magnitude times cosine and sine
  logic signed [32:0] mag;
  logic               v2;
  logic signed [64:0] mx2, my2;
  logic signed [33:0] sz2;

  assign mag = $signed({1'b0, pm1[61:30]});

  always_ff @(posedge clk) begin
    if (en) begin
      mx2 <= 65'(mag) * 65'(c1);
      my2 <= 65'(mag) * 65'(s1);
      sz2 <= 34'(pz1 >>> 30);
    end
  end

  // Stage 3: add center and saturate into the output register
  logic signed [35:0] sx, sy, sz;
  logic signed [34:0] ox, oy;

  assign ox = 35'(mx2 >>> 30);
  assign oy = 35'(my2 >>> 30);
  assign sx = 36'(cfg.center_x) + 36'(ox);
  assign sy = 36'(cfg.center_y) + 36'(oy);
  assign sz = 36'(cfg.center_z) + 36'(sz2);

  always_ff @(posedge clk) begin
    if (en) begin
      point_x <= sat32(sx);
      point_y <= sat32(sy);
      point_z <= cfg.mode ? sat32(sz) : 32'sd0;
    end
  end

  // Hold valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= vin;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Clamped unit vector stays inside [-1, 1]
  assert property (@(posedge clk) disable iff (rst)
    v1 |-> (c1 <= 32'sd1073741824 && c1 >= -32'sd1073741824 &&
            s1 <= 32'sd1073741824 && s1 >= -32'sd1073741824))
    else $error("unit vector out of range");

  // A stalled output keeps its point
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid) && $stable(point_x) && $stable(point_y))
    else $error("output changed during stall");

  // Valid moves one stage per advance
  assert property (@(posedge clk) disable iff (rst)
    en && v2 |=> out_valid)
    else $error("result lost in output stage");

endmodule

// ----- rtl/core/ball_point_sampler.sv -----
// Top level: configuration registers, input prep, chain of cells, output stages.
// Pipeline: input register, then the chain of cells for the 31-digit square root and the
// rotation steps, then the output stages.
// Throughput: one item per cycle; every stage advances together whenever the output
// register is empty or its transfer completes.
// Reset: synchronous; clears all valid bits and loads mode 0, centers 0, radius 1.0.
module ball_point_sampler import bps_pkg::*; #(
  parameter int ROTATION_STAGES = ROTATION_STAGES_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [16:0]        first_uniform,
  input  logic [16:0]        second_uniform,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z
);

  localparam int N = (ROTATION_STAGES > SQRT_STEPS) ? ROTATION_STAGES : SQRT_STEPS;

  // Configuration registers
  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= 1'b0;
      cfg.center_x <= 32'sd0;
      cfg.center_y <= 32'sd0;
      cfg.center_z <= 32'sd0;
      cfg.radius   <= 31'd65536;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:     cfg.mode     <= pwdata[0];
        REG_CENTER_X: cfg.center_x <= pwdata;
        REG_CENTER_Y: cfg.center_y <= pwdata;
        REG_CENTER_Z: cfg.center_z <= pwdata;
        REG_RADIUS:   cfg.radius   <= pwdata[30:0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MODE:     prdata = {31'd0, cfg.mode};
      REG_CENTER_X: prdata = cfg.center_x;
      REG_CENTER_Y: prdata = cfg.center_y;
      REG_CENTER_Z: prdata = cfg.center_z;
      REG_RADIUS:   prdata = {1'b0, cfg.radius};
      default:      prdata = 32'd0;
    endcase
  end

  // Advance the whole pipeline when the output slot frees
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Input prep: fractions, phase split, radicand
  logic [30:0]        f1q, f2q;
  logic signed [32:0] h_wide;
  logic signed [31:0] h;
  logic [30:0]        habs;
  logic [61:0]        hsq;
  logic [61:0]        rad;
  cell_t              first;

  assign f1q    = fraction_q30(first_uniform, FRACTION_BITS);
  assign f2q    = fraction_q30(second_uniform, FRACTION_BITS);
  assign h_wide = $signed({1'b0, f1q, 1'b0}) - 33'sd1073741824;
  assign h      = h_wide[31:0];
  assign habs   = (h < 0) ? 31'(-h_wide) : 31'(h_wide);
  assign hsq    = 62'(habs) * 62'(habs);

  always_comb begin
    if (!cfg.mode) begin
      rad = {1'b0, f1q, 30'd0};
    end else if (hsq >= (62'd1 << 60)) begin
      rad = 62'd0;
    end else begin
      rad = (62'd1 << 60) - hsq;
    end
    first.x    = CORDIC_GAIN_Q30;
    first.y    = 34'sd0;
    first.z    = $signed({3'b000, f2q[27:0], 2'b00});
    first.quad = f2q[29:28];
    first.rem  = 32'd0;
    first.root = 31'd0;
    first.rad  = rad;
    first.h    = h;
  end

  // Chain of cells
  cell_t      chain [N+1];
  logic [N:0] vchain;
  logic       head_valid;
  cell_t      head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (advance) begin
      head_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      head <= first;
    end
  end

  assign vchain[0] = head_valid;
  assign chain[0]  = head;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      bps_cell #(
        .IDX (gi),
        .ROT (ROTATION_STAGES)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .en   (advance),
        .vin  (vchain[gi]),
        .din  (chain[gi]),
        .vout (vchain[gi+1]),
        .dout (chain[gi+1])
      );
    end
  endgenerate

  // Output stages
  bps_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .vin       (vchain[N]),
    .din       (chain[N]),
    .cfg       (cfg),
    .out_valid (out_valid),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z)
  );

  // An accepted input enters the first stage
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vchain[0])
    else $error("accepted item not captured");

  // Stalls freeze the cell chain
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vchain))
    else $error("chain moved during stall");

  // Square root remainder stays below 2^31 at the chain end
  assert property (@(posedge clk) disable iff (rst)
    vchain[N] |-> !chain[N].rem[31])
    else $error("square root remainder overflow");

endmodule

// ----- tb/sv/ball_point_sampler_test.sv -----
// Self-checking testbench for the ball point sampler: directed and random draws.
module ball_point_sampler_test;
  import bps_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [16:0] first_uniform = '0, second_uniform = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] point_x, point_y, point_z;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  point_t expected_points[$];
  int errors = 0;
  int sent_count = 0;
  int checked_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Model copy of the register bank
  logic mode_m;
  longint cx_m, cy_m, cz_m, rad_m;

  ball_point_sampler DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint widen_fraction(logic [16:0] raw);
    longint f;
    f = raw;
    if (f > 65536) f = 65536;
    return f << 14;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    return tbl[i];
  endfunction

  // Predict one sampled point from the two draws and the current registers
  function automatic point_t sample_point(logic [16:0] u1, logic [16:0] u2);
    longint f1, f2, x, y, z, dx, dy, c, s, mag, h, w, px, py, pz;
    longint unsigned phase, habs, hsq;
    logic [1:0] quad;
    point_t p;
    f1 = widen_fraction(u1);
    f2 = widen_fraction(u2);
    phase = (longint'(f2) << 2) & 64'hFFFF_FFFF;
    quad = phase[31:30];
    z = phase & 64'h3FFF_FFFF;
    x = 652032874;
    y = 0;
    for (int i = 0; i < ROTATION_STAGES_DEF; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = unit_clamp(c);
    s = unit_clamp(s);
    if (!mode_m) begin
      mag = floor_shift(rad_m * int_root(longint'(f1) << 30), 30);
      pz = 0;
    end else begin
      h = 2 * f1 - 64'sd1073741824;
      habs = h < 0 ? -h : h;
      hsq = habs * habs;
      w = int_root(hsq >= (64'd1 << 60) ? 0 : (64'd1 << 60) - hsq);
      mag = floor_shift(rad_m * w, 30);
      pz = cz_m + floor_shift(rad_m * h, 30);
    end
    px = cx_m + floor_shift(mag * c, 30);
    py = cy_m + floor_shift(mag * s, 30);
    p.x = clip32(px);
    p.y = clip32(py);
    p.z = clip32(pz);
    return p;
  endfunction

  // Register write: setup cycle then access cycle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:     mode_m = val[0];
      REG_CENTER_X: cx_m = longint'(signed'(val));
      REG_CENTER_Y: cy_m = longint'(signed'(val));
      REG_CENTER_Z: cz_m = longint'(signed'(val));
      REG_RADIUS:   rad_m = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] r);
    write_reg(REG_MODE, {31'd0, m});
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_RADIUS, r);
  endtask

  // Send one draw pair, with an optional random gap first; valid stays high
  // between back-to-back transfers
  task automatic send_draws(logic [16:0] u1, logic [16:0] u2);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    first_uniform <= u1;
    second_uniform <= u2;
    expected_points.push_back(sample_point(u1, u2));
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Drop valid and hold until every expected point has come back
  task automatic wait_empty();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic wait_drain();
    wait_empty();
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_fraction();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'(65537 + $urandom_range(65534));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic test_directed_disk();
    set_config(1'b0, 32'd0, 32'd0, 32'h1234_5678, 32'd65536);
    send_draws(17'd0, 17'd0);
    send_draws(17'd65536, 17'd0);
    send_draws(17'd65536, 17'd16384);
    send_draws(17'd65536, 17'd32768);
    send_draws(17'd65536, 17'd49152);
    send_draws(17'd65536, 17'd65536);
    send_draws(17'h1FFFF, 17'h1FFFF);
    send_draws(17'd32768, 17'd8192);
    wait_drain();
    // Saturate at the coordinate limits
    set_config(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
    send_draws(17'd65536, 17'd0);
    send_draws(17'd65536, 17'd32768);
    send_draws(17'd65536, 17'd16384);
    send_draws(17'd65536, 17'd49152);
    wait_drain();
  endtask

  task automatic test_directed_sphere();
    set_config(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_draws(17'd0, 17'd0);
    send_draws(17'd65536, 17'd0);
    send_draws(17'd32768, 17'd12345);
    send_draws(17'h10001, 17'h1FFFF);
    send_draws(17'd16384, 17'd40000);
    wait_drain();
    set_config(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_draws(17'd65536, 17'd9000);
    send_draws(17'd0, 17'd60000);
    wait_drain();
  endtask

  // Random draws in one idling phase with a random register setting
  task automatic test_random_phase(int n, int snd, int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    set_config(1'($urandom_range(1)), $urandom, $urandom, $urandom,
               ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000));
    for (int i = 0; i < n; i++) begin
      send_draws(rand_fraction(), rand_fraction());
      // Hold off once, halfway through the phase, until the pipeline is empty
      if (i == n / 2) wait_empty();
    end
    wait_drain();
  endtask

  // Receiver stalls and result checks
  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_count++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point %h %h %h", $time, point_x, point_y, point_z);
          errors++;
        end else begin
          e = expected_points.pop_front();
          if (point_x !== e.x) begin
            $display("%0t: point_x expected %h actual %h", $time, e.x, point_x);
            errors++;
          end
          if (point_y !== e.y) begin
            $display("%0t: point_y expected %h actual %h", $time, e.y, point_y);
            errors++;
          end
          if (point_z !== e.z) begin
            $display("%0t: point_z expected %h actual %h", $time, e.z, point_z);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    mode_m = 1'b0; cx_m = 0; cy_m = 0; cz_m = 0; rad_m = 65536;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_disk();
    test_directed_sphere();
    test_random_phase(60, 0, 0);
    test_random_phase(60, 0, 0);
    test_random_phase(70, 61, 0);
    test_random_phase(70, 0, 61);
    test_random_phase(70, 26, 26);
    test_random_phase(70, 61, 0);
    test_random_phase(70, 0, 61);
    test_random_phase(40, 26, 26);
    $display("Covered %0d draw pairs, %0d points checked, disk and sphere modes,",
             sent_count, checked_count);
    $display("saturation, wrapped angles, over-range draws and random idling.");
    if (errors == 0 && expected_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
